// ===== hdl/blr_pkg.sv =====
// Package for the block link receiver: character codes, phase and status codes,
// configuration and result structures shared by all modules of the block.
// No dependencies.
package blr_pkg;

  localparam int unsigned MaxBuffer = 1024;
  localparam int unsigned IndexW    = $clog2(MaxBuffer);
  localparam int unsigned CountW    = IndexW + 1;

  localparam logic [CountW-1:0] MaxBufferCnt = CountW'(MaxBuffer);

  localparam logic [7:0] CharStx = 8'h02;
  localparam logic [7:0] CharEtx = 8'h03;
  localparam logic [7:0] CharDle = 8'h10;
  localparam logic [7:0] CharNak = 8'h15;
  localparam logic [7:0] CharEtb = 8'h17;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_BYTE  = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_WAIT_STX  = 3'd1,
    PH_DATA      = 3'd2,
    PH_AFTER_DLE = 3'd3,
    PH_CHECK_ETX = 3'd4,
    PH_CHECK_ETB = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_CHAR_TIMEOUT = 3'd1,
    ST_NOT_STX      = 3'd2,
    ST_OVERFLOW     = 3'd3,
    ST_CHECK_ERROR  = 3'd4,
    ST_NO_STX       = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    REG_WAIT_TICKS = 2'd0,
    REG_CHAR_TICKS = 2'd1,
    REG_BUFFER_LEN = 2'd2
  } reg_e;

  typedef struct packed {
    logic [7:0]        wait_ticks;
    logic [15:0]       char_ticks;
    logic [CountW-1:0] buffer_len;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic              store_valid;
    logic [9:0]        store_index;
    logic [7:0]        store_byte;
    logic              send_valid;
    logic [7:0]        send_byte;
    logic              done_res;
    logic [2:0]        status;
    logic [CountW-1:0] committed_len;
  } result_t;

endpackage

// ===== hdl/blr_cfg_regs.sv =====
// Configuration register file of the block link receiver, reached through
// a simple APB-style slave port. Depends on blr_pkg.
module blr_cfg_regs import blr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wait_ticks <= 8'd100;
      cfg_q.char_ticks <= 16'd220;
      cfg_q.buffer_len <= MaxBufferCnt;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WAIT_TICKS: cfg_q.wait_ticks <= pwdata[7:0];
        REG_CHAR_TICKS: cfg_q.char_ticks <= pwdata[15:0];
        REG_BUFFER_LEN: cfg_q.buffer_len <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WAIT_TICKS: prdata = {24'd0, cfg_q.wait_ticks};
      REG_CHAR_TICKS: prdata = {16'd0, cfg_q.char_ticks};
      REG_BUFFER_LEN: prdata = {{(32-CountW){1'b0}}, cfg_q.buffer_len};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/blr_proto_fsm.sv =====
// Protocol state machine of the block link receiver: phase, block check,
// write pointer, committed count and tick counter. Depends on blr_pkg.
module blr_proto_fsm import blr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [1:0] func_i,
  input  logic [7:0] rx_byte_i,
  input  cfg_t       cfg_i,
  output result_t    res_o
);

  phase_e            phase_q, phase_d;
  logic [7:0]        check_q, check_d;
  logic [CountW-1:0] wr_idx_q, wr_idx_d;
  logic [CountW-1:0] commit_q, commit_d;
  logic [15:0]       tick_q, tick_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      check_q  <= 8'd0;
      wr_idx_q <= '0;
      commit_q <= '0;
      tick_q   <= 16'd0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      check_q  <= check_d;
      wr_idx_q <= wr_idx_d;
      commit_q <= commit_d;
      tick_q   <= tick_d;
    end
  end

  always_comb begin
    logic [CountW-1:0] room;
    logic [7:0]        chk_x;
    logic [15:0]       limit;
    logic [15:0]       tick_inc;
    logic              do_store;
    logic [7:0]        store_b;

    phase_d  = phase_q;
    check_d  = check_q;
    wr_idx_d = wr_idx_q;
    commit_d = commit_q;
    tick_d   = tick_q;
    res_o    = '0;
    do_store = 1'b0;
    store_b  = rx_byte_i;

    room     = (cfg_i.buffer_len > MaxBufferCnt) ? MaxBufferCnt : cfg_i.buffer_len;
    chk_x    = check_q ^ rx_byte_i;
    limit    = (phase_q == PH_WAIT_STX) ? {8'd0, cfg_i.wait_ticks} : cfg_i.char_ticks;
    tick_inc = tick_q + 16'd1;

    case (func_i)
      FUNC_START: begin
        phase_d  = PH_WAIT_STX;
        check_d  = 8'd0;
        wr_idx_d = '0;
        commit_d = '0;
        tick_d   = 16'd0;
      end
      FUNC_BYTE: begin
        if (phase_q != PH_IDLE) begin
          tick_d = 16'd0;
        end
        case (phase_q)
          PH_WAIT_STX: begin
            res_o.valid      = 1'b1;
            res_o.send_valid = 1'b1;
            if (rx_byte_i != CharStx) begin
              res_o.send_byte = CharNak;
              res_o.done_res  = 1'b1;
              res_o.status    = ST_NOT_STX;
              phase_d         = PH_IDLE;
            end else begin
              res_o.send_byte = CharDle;
              check_d         = 8'd0;
              phase_d         = PH_DATA;
            end
          end
          PH_DATA: begin
            check_d = chk_x;
            if (rx_byte_i == CharDle) begin
              phase_d = PH_AFTER_DLE;
            end else begin
              do_store = 1'b1;
            end
          end
          PH_AFTER_DLE: begin
            check_d = chk_x;
            if (rx_byte_i == CharDle) begin
              do_store = 1'b1;
            end else if (rx_byte_i == CharEtx) begin
              phase_d = PH_CHECK_ETX;
            end else if (rx_byte_i == CharEtb) begin
              phase_d = PH_CHECK_ETB;
            end else begin
              res_o.valid      = 1'b1;
              res_o.send_valid = 1'b1;
              res_o.send_byte  = CharNak;
              res_o.done_res   = 1'b1;
              res_o.status     = ST_CHECK_ERROR;
              phase_d          = PH_IDLE;
            end
          end
          PH_CHECK_ETX, PH_CHECK_ETB: begin
            res_o.valid      = 1'b1;
            res_o.send_valid = 1'b1;
            if (rx_byte_i != check_q) begin
              res_o.send_byte = CharNak;
              res_o.done_res  = 1'b1;
              res_o.status    = ST_CHECK_ERROR;
              phase_d         = PH_IDLE;
            end else begin
              res_o.send_byte = CharDle;
              commit_d        = wr_idx_q;
              if (phase_q == PH_CHECK_ETX) begin
                res_o.done_res = 1'b1;
                res_o.status   = ST_OK;
                phase_d        = PH_IDLE;
              end else begin
                phase_d = PH_WAIT_STX;
              end
            end
          end
          default: ;
        endcase
      end
      FUNC_TICK: begin
        if (phase_q != PH_IDLE) begin
          if (tick_inc < limit) begin
            tick_d = tick_inc;
          end else begin
            tick_d         = 16'd0;
            res_o.valid    = 1'b1;
            res_o.done_res = 1'b1;
            res_o.status   = (phase_q == PH_WAIT_STX) ? ST_NO_STX : ST_CHAR_TIMEOUT;
            phase_d        = PH_IDLE;
          end
        end
      end
      default: ;
    endcase

    // A data byte, plain or from a doubled DLE, either lands in the buffer
    // or ends reception with an overflow and no reply.
    if (do_store) begin
      res_o.valid = 1'b1;
      if (wr_idx_q >= room) begin
        res_o.done_res = 1'b1;
        res_o.status   = ST_OVERFLOW;
        phase_d        = PH_IDLE;
      end else begin
        res_o.store_valid = 1'b1;
        res_o.store_index = wr_idx_q[IndexW-1:0];
        res_o.store_byte  = store_b;
        wr_idx_d          = wr_idx_q + CountW'(1);
        phase_d           = PH_DATA;
      end
    end

    res_o.committed_len = commit_d;
  end

endmodule

// ===== hdl/block_link_receiver_core.sv =====
// Top level of the block link receiver: input register, protocol state
// machine, result register and configuration port. Depends on blr_pkg,
// blr_cfg_regs and blr_proto_fsm.
//
//  Channel   Direction  Carries
//  s_axis    in         tuser = func, tdata = rx_byte
//  m_axis    out        tuser = store/send/done flags, tdata = index, bytes, status, length
//  apb       in/out     wait_ticks @0x0, char_ticks @0x4, buffer_len @0x8
//
// One item per clock is taken unless a result waits on a stalled m_axis; an item
// that gives a result passes the input register, then the result register, to m_axis.
// Reset empties both registers and returns the receiver to idle.
// A stalled m_axis holds only items that give a result; items without a
// result pass the state machine even while the result register is full.
module block_link_receiver_core import blr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,  // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [9:0] store_index, [17:10] store_byte, [25:18] send_byte,
  // [28:26] status, [39:29] committed_len
  output logic [39:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,  // [0] store_valid, [1] send_valid, [2] done_res
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t        cfg;
  result_t     res;
  logic        in_valid_q;
  logic [1:0]  in_func_q;
  logic [7:0]  in_byte_q;
  logic        advance;
  logic        out_valid_q;
  result_t     out_q;

  blr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  blr_proto_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .func_i    (in_func_q),
    .rx_byte_i (in_byte_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  assign advance       = in_valid_q && (!res.valid || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func_q <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = {out_q.done_res, out_q.send_valid, out_q.store_valid};
  assign m_axis_tdata  = {out_q.committed_len, out_q.status, out_q.send_byte,
                          out_q.store_byte, out_q.store_index};

  // Items that give no result must never wait for the output side.
  a_no_result_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !res.valid) |-> advance)
    else $error("item without result stalled");

  // A stored byte always lies inside the configured buffer.
  a_store_in_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res.store_valid) |->
      ({1'b0, res.store_index} < cfg.buffer_len))
    else $error("store outside buffer");

  // The committed length never exceeds the buffer size.
  a_commit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.committed_len <= MaxBufferCnt))
    else $error("committed length beyond buffer");

endmodule
